FILE: rtl/mktd_pkg.sv
// Shared types, constants and the Morse code table of the key timing decoder.
package mktd_pkg;

    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned TOL_W    = 10;
    localparam int unsigned CFG_IDX_W = 3;
    // Durations past this width never fall inside a window
    localparam int unsigned DUR_W    = 17;
    // Longest pattern the code table knows
    localparam int unsigned TABLE_SYMBOLS = 5;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    localparam logic [CFG_IDX_W-1:0] REG_DOT        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DASH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd4;

    typedef enum logic [1:0] {
        EDGE_NONE,
        EDGE_PRESS,
        EDGE_RELEASE
    } t_edge;

    // One entry of the queue: a decoded character and/or a trailing space
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              has_ch;
        logic              has_space;
    } t_job;

    // Index is (1 << length) | symbols, dash = 1, first symbol most significant
    function automatic logic [CHAR_W-1:0] code_lookup(input logic [5:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            6'd2:  c = 7'h45;  6'd3:  c = 7'h54;
            6'd4:  c = 7'h49;  6'd5:  c = 7'h41;  6'd6:  c = 7'h4E;  6'd7:  c = 7'h4D;
            6'd8:  c = 7'h53;  6'd9:  c = 7'h55;  6'd10: c = 7'h52;  6'd11: c = 7'h57;
            6'd12: c = 7'h44;  6'd13: c = 7'h4B;  6'd14: c = 7'h47;  6'd15: c = 7'h4F;
            6'd16: c = 7'h48;  6'd17: c = 7'h56;  6'd18: c = 7'h46;  6'd20: c = 7'h4C;
            6'd22: c = 7'h50;  6'd23: c = 7'h4A;  6'd24: c = 7'h42;  6'd25: c = 7'h58;
            6'd26: c = 7'h43;  6'd27: c = 7'h59;  6'd28: c = 7'h5A;  6'd29: c = 7'h51;
            6'd32: c = 7'h35;  6'd33: c = 7'h34;  6'd35: c = 7'h33;  6'd39: c = 7'h32;
            6'd47: c = 7'h31;  6'd48: c = 7'h36;  6'd56: c = 7'h37;  6'd60: c = 7'h38;
            6'd62: c = 7'h39;  6'd63: c = 7'h30;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/mktd_front.sv
// Front end: accepts key samples, classifies edges and keeps the symbol pattern.
module mktd_front #(
    parameter int unsigned MAX_SYMBOLS = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_key_level,
    input  logic [mktd_pkg::TIME_W-1:0]         i_time_ms,
    input  logic                                i_cfg_we,
    input  logic [mktd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mktd_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                o_push,
    output mktd_pkg::t_job                      o_job,
    input  logic                                i_full
);

    localparam int unsigned LEN_W = $clog2(MAX_SYMBOLS + 2);
    localparam int unsigned TS    = mktd_pkg::TABLE_SYMBOLS;

    function automatic logic near_value(input logic [mktd_pkg::DUR_W-1:0] d,
                                        input logic [mktd_pkg::CFG_W-1:0] nom,
                                        input logic [mktd_pkg::TOL_W-1:0] tol);
        logic [mktd_pkg::DUR_W:0] lo;
        logic [mktd_pkg::DUR_W:0] hi;
        lo = {1'b0, d} + (mktd_pkg::DUR_W+1)'(tol);
        hi = (mktd_pkg::DUR_W+1)'(nom) + (mktd_pkg::DUR_W+1)'(tol);
        return (lo > (mktd_pkg::DUR_W+1)'(nom)) && ({1'b0, d} < hi);
    endfunction

    logic [mktd_pkg::CFG_W-1:0] r_dot_ms, r_dash_ms, r_letter_gap_ms, r_word_gap_ms;
    logic [mktd_pkg::TOL_W-1:0] r_tolerance_ms;

    logic                          r_prev_level;
    logic [mktd_pkg::TIME_W-1:0]   r_prev_time;
    logic                          r_s1_vld;
    mktd_pkg::t_edge               r_s1_edge;
    logic [mktd_pkg::DUR_W-1:0]    r_s1_dur;
    logic                          r_s1_long;
    logic [MAX_SYMBOLS-1:0]        r_bits;
    logic [LEN_W-1:0]              r_len;

    logic [MAX_SYMBOLS-1:0]        n_bits;
    logic [LEN_W-1:0]              n_len;
    logic [mktd_pkg::TIME_W-1:0]   dif;
    mktd_pkg::t_edge               edge_kind;
    logic                          accept;
    logic                          advance;
    logic                          need_push;
    logic                          nr_dot, nr_dash, nr_letter, nr_word;
    logic [MAX_SYMBOLS+TS-1:0]     bits_ext;
    logic [TS-1:0]                 bits5;
    logic [2:0]                    len3;
    logic [5:0]                    idx;
    logic                          len_ok;
    logic [mktd_pkg::CHAR_W-1:0]   dec_ch;
    mktd_pkg::t_job                job;

    assign accept  = i_valid && o_ready;
    assign dif     = i_time_ms - r_prev_time;

    always_comb begin
        if (i_key_level && !r_prev_level) begin
            edge_kind = mktd_pkg::EDGE_PRESS;
        end else if (!i_key_level && r_prev_level) begin
            edge_kind = mktd_pkg::EDGE_RELEASE;
        end else begin
            edge_kind = mktd_pkg::EDGE_NONE;
        end
    end

    // Window tests; a duration beyond the compare width matches nothing
    assign nr_dot    = !r_s1_long && near_value(r_s1_dur, r_dot_ms, r_tolerance_ms);
    assign nr_dash   = !r_s1_long && near_value(r_s1_dur, r_dash_ms, r_tolerance_ms);
    assign nr_letter = !r_s1_long && near_value(r_s1_dur, r_letter_gap_ms, r_tolerance_ms);
    assign nr_word   = !r_s1_long && near_value(r_s1_dur, r_word_gap_ms, r_tolerance_ms);

    // Table lookup of the current pattern
    assign bits_ext = {{TS{1'b0}}, r_bits};
    assign bits5    = bits_ext[TS-1:0];
    assign len3     = r_len[2:0];
    assign len_ok   = (r_len != '0) && (r_len <= LEN_W'(TS)) && (r_len <= LEN_W'(MAX_SYMBOLS));
    assign idx      = (6'd1 << len3) | {1'b0, bits5 & 5'((6'd1 << len3) - 6'd1)};
    assign dec_ch   = len_ok ? mktd_pkg::code_lookup(idx) : mktd_pkg::CHAR_NONE;

    always_comb begin
        job    = '0;
        n_bits = r_bits;
        n_len  = r_len;
        unique case (r_s1_edge)
            mktd_pkg::EDGE_PRESS: begin
                if (nr_letter || nr_word) begin
                    job.ch     = dec_ch;
                    job.has_ch = (dec_ch != mktd_pkg::CHAR_NONE);
                    job.has_space = !nr_letter;
                    n_bits = '0;
                    n_len  = '0;
                end
            end
            mktd_pkg::EDGE_RELEASE: begin
                if (nr_dot || nr_dash) begin
                    if (r_len >= LEN_W'(MAX_SYMBOLS)) begin
                        n_len = LEN_W'(MAX_SYMBOLS + 1);
                    end else begin
                        n_bits = {r_bits[MAX_SYMBOLS-2:0], !nr_dot};
                        n_len  = r_len + LEN_W'(1);
                    end
                end else begin
                    job.ch     = dec_ch;
                    job.has_ch = (dec_ch != mktd_pkg::CHAR_NONE);
                    n_bits = '0;
                    n_len  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign need_push = job.has_ch || job.has_space;
    // Hold the classified item while the queue is full and it has output
    assign advance   = r_s1_vld && (!need_push || !i_full);
    assign o_ready   = !r_s1_vld || advance;
    assign o_push    = advance && need_push;
    assign o_job     = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_ms        <= 16'd250;
            r_dash_ms       <= 16'd750;
            r_letter_gap_ms <= 16'd750;
            r_word_gap_ms   <= 16'd1000;
            r_tolerance_ms  <= 10'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mktd_pkg::REG_DOT:        r_dot_ms        <= i_cfg_data;
                mktd_pkg::REG_DASH:       r_dash_ms       <= i_cfg_data;
                mktd_pkg::REG_LETTER_GAP: r_letter_gap_ms <= i_cfg_data;
                mktd_pkg::REG_WORD_GAP:   r_word_gap_ms   <= i_cfg_data;
                mktd_pkg::REG_TOLERANCE:  r_tolerance_ms  <= i_cfg_data[mktd_pkg::TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_prev_time  <= '0;
            r_s1_vld     <= 1'b0;
            r_s1_edge    <= mktd_pkg::EDGE_NONE;
            r_bits       <= '0;
            r_len        <= '0;
        end else begin
            if (accept) begin
                r_prev_level <= i_key_level;
                r_prev_time  <= i_time_ms;
                r_s1_edge    <= edge_kind;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (advance) begin
                r_s1_vld <= 1'b0;
            end
            if (advance) begin
                r_bits <= n_bits;
                r_len  <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_dur  <= dif[mktd_pkg::DUR_W-1:0];
            r_s1_long <= |dif[mktd_pkg::TIME_W-1:mktd_pkg::DUR_W];
        end
    end

endmodule

FILE: rtl/mktd_queue.sv
// Two-entry queue of decode jobs between the front end and the output stage.
module mktd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mktd_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_vld,
    output mktd_pkg::t_job o_job,
    input  logic           i_pop
);

    mktd_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_job  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/mktd_back.sv
// Output stage: turns each job into one or two result items.
module mktd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_job_vld,
    input  mktd_pkg::t_job                    i_job,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mktd_pkg::CHAR_W-1:0]       o_char_code,
    output logic                              o_last_of_run
);

    logic                            r_vld;
    logic                            r_pend_space;
    logic [mktd_pkg::CHAR_W-1:0]     r_char;
    logic                            r_last;
    logic                            load;

    // Take a new job once the output register is free and no space waits
    assign load          = !r_pend_space && (!r_vld || i_ready);
    assign o_pop         = load && i_job_vld;
    assign o_valid       = r_vld;
    assign o_char_code   = r_char;
    assign o_last_of_run = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= 1'b0;
            r_pend_space <= 1'b0;
        end else if (load) begin
            r_vld        <= i_job_vld;
            r_pend_space <= i_job_vld && i_job.has_ch && i_job.has_space;
        end else if (r_pend_space && i_ready) begin
            r_pend_space <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_job_vld) begin
            if (i_job.has_ch) begin
                r_char <= i_job.ch;
                r_last <= !i_job.has_space;
            end else begin
                r_char <= mktd_pkg::CHAR_SPACE;
                r_last <= 1'b1;
            end
        end else if (r_pend_space && i_ready) begin
            r_char <= mktd_pkg::CHAR_SPACE;
            r_last <= 1'b1;
        end
    end

endmodule

FILE: rtl/morse_key_timing_decoder.sv
// Morse key timing decoder top level: front end, job queue and output stage.
// Path: a sample's result passes the classify register, the queue write and the
// output register load; a word gap adds its space once its letter is taken.
// Throughput: one sample per cycle while the queue has room; the output register
// sends one result per cycle while ready; a two-result job holds up the next.
// Reset (synchronous, active low) restores the register defaults, clears the
// pattern, level and timestamp, and empties the queue; no clearing pass.
module morse_key_timing_decoder #(
    parameter int unsigned MAX_SYMBOLS = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_key_level,
    input  logic [mktd_pkg::TIME_W-1:0]       i_time_ms,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mktd_pkg::CHAR_W-1:0]       o_char_code,
    output logic                              o_last_of_run,
    input  logic                              i_cfg_we,
    input  logic [mktd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mktd_pkg::CFG_W-1:0]        i_cfg_data
);

    logic           push;
    logic           full;
    logic           q_vld;
    logic           pop;
    mktd_pkg::t_job front_job;
    mktd_pkg::t_job q_job;

    mktd_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_key_level (i_key_level),
        .i_time_ms   (i_time_ms),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_job       (front_job),
        .i_full      (full)
    );

    mktd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .o_vld   (q_vld),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    mktd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_vld     (q_vld),
        .i_job         (q_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_char_code   (o_char_code),
        .o_last_of_run (o_last_of_run)
    );

endmodule

FILE: tb/morse_key_timing_decoder_test.sv
// Self-checking testbench for the Morse key timing decoder: timed key samples in, characters out.
`timescale 1ns / 100ps

module morse_key_timing_decoder_test;

    localparam int unsigned PATTERN_SLOTS = 5;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned REPORT_MAX    = 10;
    localparam byte         NO_LETTER     = "*";

    typedef struct packed {
        logic [mktd_pkg::CFG_W-1:0] dot;
        logic [mktd_pkg::CFG_W-1:0] dash;
        logic [mktd_pkg::CFG_W-1:0] lgap;
        logic [mktd_pkg::CFG_W-1:0] wgap;
        logic [mktd_pkg::TOL_W-1:0] tol;
    } t_key_timing;

    typedef struct packed {
        logic [mktd_pkg::CHAR_W-1:0] ch;
        logic                        last_flag;
    } t_char_item;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    localparam t_key_timing RESET_TIMING =
        '{dot: 16'd250, dash: 16'd750, lgap: 16'd750, wgap: 16'd1000, tol: 10'd5};

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic                           i_key_level = 1'b0;
    logic [mktd_pkg::TIME_W-1:0]    i_time_ms = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [mktd_pkg::CHAR_W-1:0]    o_char_code;
    logic                           o_last_of_run;
    logic                           i_cfg_we = 1'b0;
    logic [mktd_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [mktd_pkg::CFG_W-1:0]     i_cfg_data = '0;

    // Decoder model state, advanced on every accepted item
    t_key_timing                 timing = RESET_TIMING;
    logic                        last_level = 1'b0;
    logic [mktd_pkg::TIME_W-1:0] last_stamp = '0;
    logic [4:0]                  sym_bits = '0;
    logic [2:0]                  sym_count = '0;

    t_char_item                  pending_chars[$];
    t_char_item                  head_item;
    logic [mktd_pkg::TIME_W-1:0] now_ms = '0;
    int unsigned                 items_sent = 0;
    int unsigned                 mismatches = 0;
    int unsigned                 cycle_count = 0;
    int unsigned                 send_idle_pct = 0;
    int unsigned                 stall_pct = 0;
    int unsigned                 hold_left = 0;

    morse_key_timing_decoder #(
        .MAX_SYMBOLS(PATTERN_SLOTS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_key_level  (i_key_level),
        .i_time_ms    (i_time_ms),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_char_code  (o_char_code),
        .o_last_of_run(o_last_of_run),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: a requested hold-off wins over random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch: %s", what);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %h last %b",
                                          o_char_code, o_last_of_run));
            end else begin
                head_item = pending_chars.pop_front();
                if (o_char_code !== head_item.ch || o_last_of_run !== head_item.last_flag)
                    report_mismatch($sformatf("expected char %h last %b, got char %h last %b",
                                              head_item.ch, head_item.last_flag,
                                              o_char_code, o_last_of_run));
            end
        end
    end

    // Letter for a pattern of len symbols, first symbol most significant, dash = 1
    function automatic logic [mktd_pkg::CHAR_W-1:0] morse_char(input logic [2:0] len,
                                                               input logic [4:0] bits);
        string row;
        int    pos;
        byte   c;
        case (len)
            3'd1: row = "ET";
            3'd2: row = "IANM";
            3'd3: row = "SURWDKGO";
            3'd4: row = "HVF*L*PJBXCYZQ**";
            3'd5: row = "54*3***2*******16*******7***8*90";
            default: row = "";
        endcase
        if (row.len() == 0)
            return mktd_pkg::CHAR_NONE;
        pos = bits & ((1 << len) - 1);
        c = row[pos];
        if (c == NO_LETTER)
            return mktd_pkg::CHAR_NONE;
        return c[mktd_pkg::CHAR_W-1:0];
    endfunction

    function automatic logic [mktd_pkg::CHAR_W-1:0] take_letter();
        logic [mktd_pkg::CHAR_W-1:0] c;
        c = morse_char(sym_count, sym_bits);
        sym_bits  = '0;
        sym_count = '0;
        return c;
    endfunction

    function automatic void add_symbol(input logic dash);
        if (sym_count >= PATTERN_SLOTS) begin
            sym_count = 3'(PATTERN_SLOTS + 1);
        end else begin
            sym_bits  = {sym_bits[3:0], dash};
            sym_count = sym_count + 3'd1;
        end
    endfunction

    // Strict window around the nominal, no wrap
    function automatic bit in_window(input logic [mktd_pkg::TIME_W-1:0] span,
                                     input logic [mktd_pkg::CFG_W-1:0] nominal);
        longint unsigned d = span;
        longint unsigned n = nominal;
        longint unsigned t = timing.tol;
        return (d + t > n) && (d < n + t);
    endfunction

    function automatic void predict_sample(input logic level,
                                           input logic [mktd_pkg::TIME_W-1:0] stamp);
        logic [mktd_pkg::TIME_W-1:0] span;
        logic [mktd_pkg::CHAR_W-1:0] c;
        logic [mktd_pkg::CHAR_W-1:0] outs[$];
        span = stamp - last_stamp;
        if (level && !last_level) begin
            if (in_window(span, timing.lgap)) begin
                c = take_letter();
                if (c != mktd_pkg::CHAR_NONE) outs.push_back(c);
            end else if (in_window(span, timing.wgap)) begin
                c = take_letter();
                if (c != mktd_pkg::CHAR_NONE) outs.push_back(c);
                outs.push_back(mktd_pkg::CHAR_SPACE);
            end
        end else if (!level && last_level) begin
            if (in_window(span, timing.dot)) begin
                add_symbol(1'b0);
            end else if (in_window(span, timing.dash)) begin
                add_symbol(1'b1);
            end else begin
                c = take_letter();
                if (c != mktd_pkg::CHAR_NONE) outs.push_back(c);
            end
        end
        last_stamp = stamp;
        last_level = level;
        foreach (outs[k])
            pending_chars.push_back('{ch: outs[k], last_flag: (k == outs.size() - 1)});
    endfunction

    // Returns just after the accepting edge; valid stays up until the next call or a drain
    task automatic send_sample(input logic level, input logic [mktd_pkg::TIME_W-1:0] stamp);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_key_level <= level;
        i_time_ms   <= stamp;
        do @(posedge i_clk); while (!o_ready);
        predict_sample(level, stamp);
        items_sent++;
    endtask

    task automatic key_after(input logic level, input int unsigned span);
        now_ms += span;
        send_sample(level, now_ms);
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge i_clk);
        // a decode with no character may still be in flight
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mktd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mktd_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            mktd_pkg::REG_DOT:        timing.dot  = data;
            mktd_pkg::REG_DASH:       timing.dash = data;
            mktd_pkg::REG_LETTER_GAP: timing.lgap = data;
            mktd_pkg::REG_WORD_GAP:   timing.wgap = data;
            mktd_pkg::REG_TOLERANCE:  timing.tol  = data[mktd_pkg::TOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_timing(input t_key_timing t);
        write_reg(mktd_pkg::REG_DOT, t.dot);
        write_reg(mktd_pkg::REG_DASH, t.dash);
        write_reg(mktd_pkg::REG_LETTER_GAP, t.lgap);
        write_reg(mktd_pkg::REG_WORD_GAP, t.wgap);
        write_reg(mktd_pkg::REG_TOLERANCE, 16'(t.tol));
    endtask

    function automatic void set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 46; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 46; end
            default:       begin send_idle_pct = 38; stall_pct = 38; end
        endcase
    endfunction

    // Mostly inside the window, now and then exactly on its open edge
    function automatic int unsigned near_dur(input logic [mktd_pkg::CFG_W-1:0] nominal);
        int unsigned n = nominal;
        int unsigned t = timing.tol;
        if (t == 0)
            return n;
        if ($urandom_range(9) == 0)
            return (n >= t && $urandom_range(1)) ? n - t : n + t;
        return $urandom_range(n + t - 1, (n >= t) ? n - t + 1 : 0);
    endfunction

    function automatic int unsigned symbol_gap();
        if ($urandom_range(9) < 7)
            return near_dur(timing.dot);
        return $urandom_range(3 * timing.dot, 1);
    endfunction

    function automatic int unsigned stray_dur();
        return $urandom_range(1) ? $urandom_range(200000, 0) : $urandom;
    endfunction

    function automatic int unsigned press_dur();
        if ($urandom_range(99) < 12)
            return stray_dur();
        return $urandom_range(1) ? near_dur(timing.dash) : near_dur(timing.dot);
    endfunction

    // One keyed letter with random symbols, then a random way of ending it
    task automatic send_letter();
        int unsigned len;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            len = 0;
        else if (roll < 92)
            len = $urandom_range(5, 1);
        else
            len = $urandom_range(7, 6);
        for (int s = 0; s < len; s++) begin
            if (!last_level)
                key_after(1'b1, symbol_gap());
            key_after(1'b0, press_dur());
        end
        if (last_level)
            key_after(1'b0, stray_dur());
        roll = $urandom_range(99);
        if (roll < 45) begin
            key_after(1'b1, near_dur(timing.lgap));
        end else if (roll < 75) begin
            key_after(1'b1, near_dur(timing.wgap));
        end else if (roll < 88) begin
            key_after(1'b1, symbol_gap());
            key_after(1'b0, stray_dur());
        end else if (roll < 94) begin
            key_after(last_level, symbol_gap());
        end else begin
            now_ms = $urandom;
            send_sample(1'($urandom_range(1)), now_ms);
        end
    endtask

    task automatic test_directed();
        send_sample(1'b0, '0);
        now_ms = '1;
        send_sample(1'b0, now_ms);
        // press across the timestamp wrap, away from any gap
        key_after(1'b1, 300);
        key_after(1'b0, timing.dot + 4);
        key_after(1'b1, timing.lgap + 1);
        key_after(1'b0, timing.dash - 4);
        key_after(1'b1, timing.wgap + 4);
        // release on the open edge of the dot window decodes an empty pattern
        key_after(1'b0, timing.dot + timing.tol);
        key_after(1'b1, timing.wgap);
        // digit four
        key_after(1'b0, timing.dot);
        key_after(1'b1, timing.dot);
        key_after(1'b0, timing.dot - 4);
        key_after(1'b1, timing.dot);
        key_after(1'b0, timing.dot);
        key_after(1'b1, timing.dot);
        key_after(1'b0, timing.dot);
        key_after(1'b1, timing.dot);
        key_after(1'b0, timing.dash + 4);
        key_after(1'b1, timing.wgap - timing.tol);
        key_after(1'b0, 2 * timing.wgap);
        // pattern with no letter
        key_after(1'b1, timing.dot);
        key_after(1'b0, timing.dot);
        key_after(1'b1, timing.dot);
        key_after(1'b0, timing.dot);
        key_after(1'b1, timing.dot);
        key_after(1'b0, timing.dash);
        key_after(1'b1, timing.dot);
        key_after(1'b0, timing.dash);
        key_after(1'b1, timing.lgap);
    endtask

    task automatic test_timing_sweep();
        t_key_timing sets[8];
        int unsigned d;
        int unsigned phase_end;
        sets[0] = RESET_TIMING;
        sets[1] = '{dot: 16'd250, dash: 16'd750, lgap: 16'd750, wgap: 16'd1000, tol: 10'd0};
        sets[2] = '{dot: 16'd1, dash: 16'd2, lgap: 16'd3, wgap: 16'd4, tol: 10'd1023};
        sets[3] = '{dot: 16'hFFFF, dash: 16'hFFFF, lgap: 16'hFFFF, wgap: 16'hFFFF,
                    tol: 10'd1023};
        sets[4] = '{dot: 16'd100, dash: 16'd90, lgap: 16'd300, wgap: 16'd310, tol: 10'd20};
        sets[5] = '{dot: 16'd60, dash: 16'd180, lgap: 16'd180, wgap: 16'd420, tol: 10'd1};
        for (int p = 0; p < 8; p++) begin
            wait_results_done();
            if (p >= 6) begin
                d = $urandom_range(4000, 1);
                sets[p] = '{dot: 16'(d), dash: 16'(3 * d), lgap: 16'(3 * d),
                            wgap: 16'(7 * d),
                            tol: 10'($urandom_range((d < 1023) ? d : 1023, 1))};
                // unmapped register indexes must be ignored
                for (int idx = mktd_pkg::REG_TOLERANCE + 1; idx < (1 << mktd_pkg::CFG_IDX_W);
                     idx++)
                    write_reg(mktd_pkg::CFG_IDX_W'(idx), mktd_pkg::CFG_W'($urandom));
            end
            load_timing(sets[p]);
            set_idling(t_idle_mode'(p % 4));
            // nothing ever matches with zero tolerance, so keep that phase short
            phase_end = items_sent + ((p == 1) ? 60 : 170);
            while (items_sent < phase_end)
                send_letter();
        end
    endtask

    task automatic test_backpressure();
        int unsigned stop_at;
        wait_results_done();
        load_timing(RESET_TIMING);
        set_idling(IDLE_NONE);
        @(posedge i_clk);
        hold_left = 600;
        stop_at = items_sent + 200;
        while (items_sent < stop_at)
            send_letter();
        // pause the sender until every character is out
        wait_results_done();
        set_idling(IDLE_BOTH);
        stop_at = items_sent + 80;
        while (items_sent < stop_at)
            send_letter();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_timing_sweep();
        test_backpressure();
        wait_results_done();
        if (pending_chars.size() != 0)
            report_mismatch($sformatf("%0d expected characters never came",
                                      pending_chars.size()));
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
